[design/dedd_pkg.sv]
`timescale 1ns / 1ps
// dedd_pkg: widths, constants and shared types of the dual ema dip detector
// no dependencies; imported by the lane, merge and top level modules

package dedd_pkg;

    localparam int SAMPLE_BITS = 12;
    localparam int SHIFT_W     = 4;
    localparam int GAIN_W      = 6;
    localparam int FAST_W      = 20;
    localparam int BASE_W      = 24;
    localparam int SUM_W       = BASE_W + 1;
    localparam int AMP_W       = SAMPLE_BITS + GAIN_W;
    localparam int DAC_N_W     = 18;
    localparam int RECIP_W     = 19;
    localparam int PROD_W      = DAC_N_W + RECIP_W;
    localparam int RECIP_SHIFT = 24;
    localparam int IDX_W       = 3;
    localparam int S_DATA_W    = 24;
    localparam int M_DATA_W    = 64;

    localparam logic [SAMPLE_BITS-1:0] SAMPLE_MAX = {SAMPLE_BITS{1'b1}};
    localparam logic [SAMPLE_BITS-1:0] DAC_MAX    = 12'd4095;
    localparam logic [SAMPLE_BITS-1:0] LED_LEVEL  = 12'd2048;

    // scaling by 33/50 with rounding; divide by 50 as a reciprocal multiply
    localparam logic [DAC_N_W-1:0] SCALE_NUM   = 18'd33;
    localparam logic [DAC_N_W-1:0] SCALE_ROUND = 18'd25;
    localparam logic [RECIP_W-1:0] DAC_RECIP   = 19'd335545;

    localparam logic [FAST_W-1:0] FAST_ACC_RESET = 20'(2048 << 5);
    localparam logic [BASE_W-1:0] BASE_ACC_RESET = 24'(2048 << 9);

    localparam logic [SHIFT_W-1:0] FAST_SHIFT_MIN = 4'd1;
    localparam logic [SHIFT_W-1:0] FAST_SHIFT_MAX = 4'd8;
    localparam logic [SHIFT_W-1:0] BASE_SHIFT_MIN = 4'd1;
    localparam logic [SHIFT_W-1:0] BASE_SHIFT_MAX = 4'd12;

    // register indexes of the configuration channel
    localparam logic [IDX_W-1:0] REG_FAST_SHIFT   = 3'd0;
    localparam logic [IDX_W-1:0] REG_BASE_SHIFT   = 3'd1;
    localparam logic [IDX_W-1:0] REG_NOISE_THRESH = 3'd2;
    localparam logic [IDX_W-1:0] REG_SMALL_THRESH = 3'd3;
    localparam logic [IDX_W-1:0] REG_GAIN_LO      = 3'd4;
    localparam logic [IDX_W-1:0] REG_GAIN_HI      = 3'd5;
    localparam logic [IDX_W-1:0] REG_DETECT_DELTA = 3'd6;

    localparam logic [SHIFT_W-1:0]     FAST_SHIFT_RESET   = 4'd5;
    localparam logic [SHIFT_W-1:0]     BASE_SHIFT_RESET   = 4'd9;
    localparam logic [SAMPLE_BITS-1:0] NOISE_THRESH_RESET = 12'd4;
    localparam logic [SAMPLE_BITS-1:0] SMALL_THRESH_RESET = 12'd16;
    localparam logic [GAIN_W-1:0]      GAIN_LO_RESET      = 6'd12;
    localparam logic [GAIN_W-1:0]      GAIN_HI_RESET      = 6'd20;
    localparam logic [SAMPLE_BITS-1:0] DETECT_DELTA_RESET = 12'd10;

    typedef struct packed {
        logic [SHIFT_W-1:0]     fast_shift;
        logic [SHIFT_W-1:0]     base_shift;
        logic [SAMPLE_BITS-1:0] noise_thresh;
        logic [SAMPLE_BITS-1:0] small_thresh;
        logic [GAIN_W-1:0]      gain_lo;
        logic [GAIN_W-1:0]      gain_hi;
        logic [SAMPLE_BITS-1:0] detect_delta;
    } dedd_cfg_t;

    typedef struct packed {
        logic load;
        logic ema_en;
        logic stage;
        logic base_en;
        logic gain_en;
        logic track_en;
    } dedd_ctl_t;

    typedef struct packed {
        logic [SAMPLE_BITS-1:0] dac;
        logic                   led;
        logic                   drop_end;
        logic [SAMPLE_BITS-1:0] drop_min;
        logic [SAMPLE_BITS-1:0] drop_base;
    } dedd_res_t;

endpackage

[design/dual_ema_dip_detector_core.sv]
`timescale 1ns / 1ps
// dual_ema_dip_detector_core: top level, configuration registers, step sequencer,
// two channel lanes and the result merge; depends on dedd_pkg, dedd_lane, dedd_merge
// sequencing: a sample pair is taken only in idle; the sequencer walks each lane's shared
// ema unit through its fast stages and the baseline, then gain and track, then output
// the merge register raises m_tvalid after OUT, which holds while the output beat is not taken
// reset: synchronous active low; config registers return to defaults, accumulators to mid-scale

module dual_ema_dip_detector_core
    import dedd_pkg::*;
(
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   s_tvalid,
    output logic                   s_tready,
    // [11:0] sample_a, [23:12] sample_b
    input  logic [S_DATA_W-1:0]    s_tdata,
    output logic                   m_tvalid,
    input  logic                   m_tready,
    // [11:0] dac_a, [23:12] dac_b, [24] red_led, [25] drop_end_a, [37:26] drop_min_a,
    // [38] drop_end_b, [50:39] drop_min_b, [62:51] drop_base_b, [63] zero
    output logic [M_DATA_W-1:0]    m_tdata,
    input  logic                   cfg_valid,
    output logic                   cfg_ready,
    input  logic [IDX_W-1:0]       cfg_index,
    input  logic [SAMPLE_BITS-1:0] cfg_data
);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_EMA0,
        ST_EMA1,
        ST_BASE,
        ST_GAIN,
        ST_TRACK,
        ST_OUT
    } state_t;

    state_t state_reg;
    state_t state_next;

    dedd_cfg_t cfg_reg;
    dedd_cfg_t cfg_eff;
    dedd_ctl_t ctl;
    dedd_res_t res_a;
    dedd_res_t res_b;
    logic      out_load;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.fast_shift   <= FAST_SHIFT_RESET;
            cfg_reg.base_shift   <= BASE_SHIFT_RESET;
            cfg_reg.noise_thresh <= NOISE_THRESH_RESET;
            cfg_reg.small_thresh <= SMALL_THRESH_RESET;
            cfg_reg.gain_lo      <= GAIN_LO_RESET;
            cfg_reg.gain_hi      <= GAIN_HI_RESET;
            cfg_reg.detect_delta <= DETECT_DELTA_RESET;
        end else if (cfg_valid && cfg_ready) begin
            case (cfg_index)
                REG_FAST_SHIFT:   cfg_reg.fast_shift   <= cfg_data[SHIFT_W-1:0];
                REG_BASE_SHIFT:   cfg_reg.base_shift   <= cfg_data[SHIFT_W-1:0];
                REG_NOISE_THRESH: cfg_reg.noise_thresh <= cfg_data;
                REG_SMALL_THRESH: cfg_reg.small_thresh <= cfg_data;
                REG_GAIN_LO:      cfg_reg.gain_lo      <= cfg_data[GAIN_W-1:0];
                REG_GAIN_HI:      cfg_reg.gain_hi      <= cfg_data[GAIN_W-1:0];
                REG_DETECT_DELTA: cfg_reg.detect_delta <= cfg_data;
                default: ;
            endcase
        end
    end

    // shifts limited to their legal range
    always_comb begin
        cfg_eff = cfg_reg;
        if (cfg_reg.fast_shift < FAST_SHIFT_MIN) begin
            cfg_eff.fast_shift = FAST_SHIFT_MIN;
        end else if (cfg_reg.fast_shift > FAST_SHIFT_MAX) begin
            cfg_eff.fast_shift = FAST_SHIFT_MAX;
        end
        if (cfg_reg.base_shift < BASE_SHIFT_MIN) begin
            cfg_eff.base_shift = BASE_SHIFT_MIN;
        end else if (cfg_reg.base_shift > BASE_SHIFT_MAX) begin
            cfg_eff.base_shift = BASE_SHIFT_MAX;
        end
    end

    assign s_tready = (state_reg == ST_IDLE);
    assign out_load = (state_reg == ST_OUT) && (!m_tvalid || m_tready);

    always_comb begin
        ctl.load     = s_tvalid && s_tready;
        ctl.ema_en   = (state_reg == ST_EMA0) || (state_reg == ST_EMA1);
        ctl.stage    = (state_reg == ST_EMA1);
        ctl.base_en  = (state_reg == ST_BASE);
        ctl.gain_en  = (state_reg == ST_GAIN);
        ctl.track_en = (state_reg == ST_TRACK);
    end

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:  if (s_tvalid) state_next = ST_EMA0;
            ST_EMA0:  state_next = ST_EMA1;
            ST_EMA1:  state_next = ST_BASE;
            ST_BASE:  state_next = ST_GAIN;
            ST_GAIN:  state_next = ST_TRACK;
            ST_TRACK: state_next = ST_OUT;
            ST_OUT:   if (out_load) state_next = ST_IDLE;
            default:  state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    dedd_lane #(
        .FAST_STAGES (1)
    ) u_lane_a (
        .aclk    (aclk),
        .aresetn (aresetn),
        .ctl     (ctl),
        .cfg     (cfg_eff),
        .sample  (s_tdata[SAMPLE_BITS-1:0]),
        .res     (res_a)
    );

    dedd_lane #(
        .FAST_STAGES (2)
    ) u_lane_b (
        .aclk    (aclk),
        .aresetn (aresetn),
        .ctl     (ctl),
        .cfg     (cfg_eff),
        .sample  (s_tdata[2*SAMPLE_BITS-1:SAMPLE_BITS]),
        .res     (res_b)
    );

    dedd_merge u_merge (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .load     (out_load),
        .res_a    (res_a),
        .res_b    (res_b),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    // a beat taken sends the sequencer off idle
    a_accept_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> !s_tready)
        else $error("input taken while a pair is in flight");

    // a finished pair waits while the output register is still full
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_OUT) && m_tvalid && !m_tready |=> (state_reg == ST_OUT))
        else $error("result left the sequencer over a full output register");

    // a new result beat only ever comes from the output step
    a_out_origin: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_tvalid) |-> $past(state_reg == ST_OUT))
        else $error("result beat appeared without an output step");

endmodule

[design/dedd_lane.sv]
`timescale 1ns / 1ps
// dedd_lane: one channel of the detector, ema chain on a shared update unit,
// gain, clamp, dip tracking and dac scaling; depends on dedd_pkg

module dedd_lane
    import dedd_pkg::*;
#(
    parameter int FAST_STAGES = 1
) (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  dedd_ctl_t              ctl,
    input  dedd_cfg_t              cfg,
    input  logic [SAMPLE_BITS-1:0] sample,
    output dedd_res_t              res
);

    logic [SAMPLE_BITS-1:0] x_reg;
    logic [FAST_W-1:0]      fast_acc_reg [FAST_STAGES];
    logic [BASE_W-1:0]      base_acc_reg;
    logic [SAMPLE_BITS-1:0] fast_reg;
    logic [SAMPLE_BITS-1:0] base_reg;
    logic [AMP_W-1:0]       amp_reg;
    logic                   in_dip_reg;
    logic [SAMPLE_BITS-1:0] run_min_reg;
    logic                   end_reg;
    logic [SAMPLE_BITS-1:0] min_reg;
    logic [SAMPLE_BITS-1:0] base_rep_reg;
    logic                   led_reg;
    logic [PROD_W-1:0]      prod_reg;

    // shared ema update unit
    logic [BASE_W-1:0]      acc_cur;
    logic [SAMPLE_BITS-1:0] ema_x;
    logic [SHIFT_W-1:0]     sh;
    logic [SUM_W-1:0]       acc_sum;
    logic [BASE_W-1:0]      acc_new;
    logic [BASE_W-1:0]      ema_out;
    logic [SAMPLE_BITS-1:0] ema_sat;

    always_comb begin
        acc_cur = {{(BASE_W-FAST_W){1'b0}}, fast_acc_reg[0]};
        ema_x   = x_reg;
        sh      = cfg.fast_shift;
        for (int k = 1; k < FAST_STAGES; k++) begin
            if (ctl.stage == 1'(k)) begin
                acc_cur = {{(BASE_W-FAST_W){1'b0}}, fast_acc_reg[k]};
                ema_x   = fast_reg;
            end
        end
        if (ctl.base_en) begin
            acc_cur = base_acc_reg;
            ema_x   = fast_reg;
            sh      = cfg.base_shift;
        end
        acc_sum = SUM_W'(acc_cur) - SUM_W'(acc_cur >> sh) + SUM_W'(ema_x);
        acc_new = ctl.base_en ? acc_sum[BASE_W-1:0]
                              : {{(BASE_W-FAST_W){1'b0}}, acc_sum[FAST_W-1:0]};
        ema_out = acc_new >> sh;
        ema_sat = (ema_out > BASE_W'(SAMPLE_MAX)) ? SAMPLE_MAX : ema_out[SAMPLE_BITS-1:0];
    end

    // gain step
    logic [SAMPLE_BITS-1:0] delta;
    logic [GAIN_W-1:0]      gain;
    logic [AMP_W-1:0]       amp;

    always_comb begin
        delta = (base_reg > fast_reg) ? base_reg - fast_reg : '0;
        gain  = (delta <= cfg.small_thresh) ? cfg.gain_lo : cfg.gain_hi;
        amp   = (delta > cfg.noise_thresh) ? AMP_W'(delta) * AMP_W'(gain) : '0;
    end

    // clamp, dip tracking and dac scaling
    logic [SAMPLE_BITS-1:0] amp_c;
    logic [SAMPLE_BITS-1:0] code;
    logic [SAMPLE_BITS-1:0] thr;
    logic [SAMPLE_BITS-1:0] run_lo;
    logic [DAC_N_W-1:0]     dac_n;
    logic [PROD_W-1:0]      dac_prod;

    always_comb begin
        amp_c    = (amp_reg > AMP_W'(base_reg)) ? base_reg : amp_reg[SAMPLE_BITS-1:0];
        code     = base_reg - amp_c;
        thr      = (base_reg > cfg.detect_delta) ? base_reg - cfg.detect_delta : '0;
        run_lo   = (code < run_min_reg) ? code : run_min_reg;
        dac_n    = DAC_N_W'(code) * SCALE_NUM + SCALE_ROUND;
        dac_prod = PROD_W'(dac_n) * PROD_W'(DAC_RECIP);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int k = 0; k < FAST_STAGES; k++) begin
                fast_acc_reg[k] <= FAST_ACC_RESET;
            end
            base_acc_reg <= BASE_ACC_RESET;
            in_dip_reg   <= 1'b0;
            run_min_reg  <= DAC_MAX;
        end else begin
            if (ctl.ema_en) begin
                for (int k = 0; k < FAST_STAGES; k++) begin
                    if (ctl.stage == 1'(k)) begin
                        fast_acc_reg[k] <= acc_new[FAST_W-1:0];
                    end
                end
            end
            if (ctl.base_en) begin
                base_acc_reg <= acc_new;
            end
            if (ctl.track_en) begin
                if (!in_dip_reg) begin
                    if (code < thr) begin
                        in_dip_reg  <= 1'b1;
                        run_min_reg <= code;
                    end
                end else if (code >= thr) begin
                    in_dip_reg  <= 1'b0;
                    run_min_reg <= DAC_MAX;
                end else begin
                    run_min_reg <= run_lo;
                end
            end
        end
    end

    // payload registers
    always_ff @(posedge aclk) begin
        if (ctl.load) begin
            x_reg <= sample;
        end
        if (ctl.ema_en && (32'(ctl.stage) < FAST_STAGES)) begin
            fast_reg <= ema_sat;
        end
        if (ctl.base_en) begin
            base_reg <= ema_sat;
        end
        if (ctl.gain_en) begin
            amp_reg <= amp;
        end
        if (ctl.track_en) begin
            end_reg      <= in_dip_reg && (code >= thr);
            min_reg      <= (in_dip_reg && (code >= thr)) ? run_lo : '0;
            base_rep_reg <= (in_dip_reg && (code >= thr)) ? base_reg : '0;
            led_reg      <= code < LED_LEVEL;
            prod_reg     <= dac_prod;
        end
    end

    assign res.dac       = prod_reg[RECIP_SHIFT +: SAMPLE_BITS];
    assign res.led       = led_reg;
    assign res.drop_end  = end_reg;
    assign res.drop_min  = min_reg;
    assign res.drop_base = base_rep_reg;

endmodule

[design/dedd_merge.sv]
`timescale 1ns / 1ps
// dedd_merge: combines the two lane results into one output beat and holds it
// in the master-side register; depends on dedd_pkg

module dedd_merge
    import dedd_pkg::*;
(
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                load,
    input  dedd_res_t           res_a,
    input  dedd_res_t           res_b,
    output logic                m_tvalid,
    input  logic                m_tready,
    output logic [M_DATA_W-1:0] m_tdata
);

    logic                valid_reg;
    logic [M_DATA_W-1:0] data_reg;
    logic [M_DATA_W-1:0] data_next;

    always_comb begin
        data_next = {1'b0,
                     res_b.drop_base,
                     res_b.drop_min,
                     res_b.drop_end,
                     res_a.drop_min,
                     res_a.drop_end,
                     res_a.led,
                     res_b.dac,
                     res_a.dac};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (load) begin
            valid_reg <= 1'b1;
        end else if (m_tready) begin
            valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            data_reg <= data_next;
        end
    end

    assign m_tvalid = valid_reg;
    assign m_tdata  = data_reg;

endmodule
